FILE: hw/rtl/fcbc_pkg.sv
// Shared types, constants and S-box tables for the Feistel CBC block cipher.
`timescale 1ns / 1ps

package fcbc_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] half_t;
  typedef logic [63:0] block_t;

  // Configuration register indexes; the index field has room for writes past the list.
  localparam int CFG_INDEX_W = 2;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  localparam cfg_index_t CFG_CIPHER_KEY = 2'd0;
  localparam cfg_index_t CFG_CHAIN_INIT = 2'd1;

  // Operation codes carried in the op field.
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // Default number of Feistel rounds.
  localparam int ROUNDS_DEFAULT = 16;

  // Forward AES S-box.
  localparam byte_t FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Inverse AES S-box.
  localparam byte_t INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Maps each byte of a word through the forward S-box.
  function automatic half_t sub_word_fwd(input half_t w);
    half_t r;
    r = '0;
    for (int b = 0; b < 4; b++) begin
      r[8*b +: 8] = FWD_SBOX[w[8*b +: 8]];
    end
    return r;
  endfunction

  // Maps each byte of a word through the inverse S-box.
  function automatic half_t sub_word_inv(input half_t w);
    half_t r;
    r = '0;
    for (int b = 0; b < 4; b++) begin
      r[8*b +: 8] = INV_SBOX[w[8*b +: 8]];
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/fcbc_in_if.sv
// Input item channel: operation, chain start flag and one data block.
`timescale 1ns / 1ps

interface fcbc_in_if;
  import fcbc_pkg::*;

  logic   valid;
  logic   ready;
  logic   op;
  logic   chain_start;
  block_t data_in;

  modport source (output valid, output op, output chain_start, output data_in, input ready);
  modport sink (input valid, input op, input chain_start, input data_in, output ready);
endinterface

FILE: hw/rtl/fcbc_out_if.sv
// Result item channel: one data block.
`timescale 1ns / 1ps

interface fcbc_out_if;
  import fcbc_pkg::*;

  logic   valid;
  logic   ready;
  block_t data_out;

  modport source (output valid, output data_out, input ready);
  modport sink (input valid, input data_out, output ready);
endinterface

FILE: hw/rtl/fcbc_cfg_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface fcbc_cfg_if;
  import fcbc_pkg::*;

  logic       valid;
  logic       ready;
  cfg_index_t index;
  block_t     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/fcbc_round.sv
// One Feistel round: swap halves and mix the left half with F(right, key).
`timescale 1ns / 1ps

module fcbc_round (
  input  fcbc_pkg::half_t l_in,
  input  fcbc_pkg::half_t r_in,
  input  fcbc_pkg::half_t round_key,
  output fcbc_pkg::half_t l_out,
  output fcbc_pkg::half_t r_out
);
  import fcbc_pkg::*;

  // Round function: key XOR followed by the inverse S-box on each byte.
  assign l_out = r_in;
  assign r_out = l_in ^ sub_word_inv(r_in ^ round_key);

endmodule

FILE: hw/rtl/fcbc_cipher.sv
// Combinational Feistel network for one block, both directions.
`timescale 1ns / 1ps

module fcbc_cipher #(
  parameter int ROUNDS = fcbc_pkg::ROUNDS_DEFAULT
) (
  input  fcbc_pkg::half_t  base_key,
  input  logic             decrypt,
  input  fcbc_pkg::block_t block_in,
  output fcbc_pkg::block_t block_out
);
  import fcbc_pkg::*;

  half_t rk   [ROUNDS];
  half_t a    [ROUNDS+1];
  half_t b    [ROUNDS+1];

  // Decryption is the same round chain on swapped halves with the key order reversed.
  assign a[0] = decrypt ? block_in[31:0]  : block_in[63:32];
  assign b[0] = decrypt ? block_in[63:32] : block_in[31:0];

  genvar i;
  generate
    for (i = 0; i < ROUNDS; i++) begin : g_round
      logic [63:0] dbl;
      half_t       key_sel;

      // Round key i is the base word rotated left by i.
      assign dbl   = {base_key, base_key} << i;
      assign rk[i] = dbl[63:32];

      assign key_sel = decrypt ? rk[ROUNDS-1-i] : rk[i];

      fcbc_round u_round (
        .l_in      (a[i]),
        .r_in      (b[i]),
        .round_key (key_sel),
        .l_out     (a[i+1]),
        .r_out     (b[i+1])
      );
    end
  endgenerate

  // Undo the swap on the way out when decrypting.
  assign block_out = decrypt ? {b[ROUNDS], a[ROUNDS]} : {a[ROUNDS], b[ROUNDS]};

endmodule

FILE: hw/rtl/feistel_cbc_block_cipher_top.sv
// Top level of the Feistel CBC block cipher: input stage, cipher, chain and result register.
`timescale 1ns / 1ps

// The block encrypts or decrypts one 64-bit item per cycle in CBC mode with a
// ROUNDS-round Feistel network keyed from a 32-bit key. An accepted item is held
// in the input stage, passes through all rounds in a single combinational pass
// and lands in the result register, and a new item is taken every cycle unless
// the input stage stalls; the chain register is updated as each item leaves the
// input stage, which is what lets the next item follow at once. The input stage
// stalls only while the result register holds an item that has not been taken.
// Configuration writes are always ready; the key is put through the forward
// S-box as it is written.

module feistel_cbc_block_cipher_top #(
  parameter int ROUNDS = fcbc_pkg::ROUNDS_DEFAULT
) (
  input logic  clk,
  input logic  rst,
  fcbc_in_if.sink    item_in,
  fcbc_out_if.source item_out,
  fcbc_cfg_if.sink   cfg
);
  import fcbc_pkg::*;

  // Configuration state.
  half_t  base_key;
  block_t chain_init;

  // Input stage.
  logic   stage_valid;
  logic   stage_op;
  logic   stage_start;
  block_t stage_data;

  // Chain and result registers.
  block_t chain_reg;
  logic   out_valid;
  block_t out_data;

  logic   adv;
  logic   stage_ready;
  logic   is_dec;
  block_t chain_cur;
  block_t cipher_in;
  block_t cipher_out;
  block_t result;
  block_t chain_next;

  // Configuration writes, key stored already substituted.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_key   <= sub_word_fwd('0);
      chain_init <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_CIPHER_KEY: base_key   <= sub_word_fwd(cfg.data[31:0]);
        CFG_CHAIN_INIT: chain_init <= cfg.data;
        default: ;
      endcase
    end
  end

  // Handshake: the stage moves on when the result register is free or being emptied.
  assign adv          = stage_valid && (!out_valid || item_out.ready);
  assign stage_ready  = !stage_valid || adv;
  assign item_in.ready = stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_ready) begin
      stage_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready && item_in.valid) begin
      stage_op    <= item_in.op;
      stage_start <= item_in.chain_start;
      stage_data  <= item_in.data_in;
    end
  end

  // CBC datapath around the Feistel network.
  assign is_dec    = (stage_op == OP_DECRYPT);
  assign chain_cur = stage_start ? chain_init : chain_reg;
  assign cipher_in = is_dec ? stage_data : (stage_data ^ chain_cur);

  fcbc_cipher #(
    .ROUNDS (ROUNDS)
  ) u_cipher (
    .base_key  (base_key),
    .decrypt   (is_dec),
    .block_in  (cipher_in),
    .block_out (cipher_out)
  );

  assign result     = is_dec ? (cipher_out ^ chain_cur) : cipher_out;
  assign chain_next = is_dec ? stage_data : cipher_out;

  // Chain register follows each item as it leaves the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_reg <= '0;
    end else if (adv) begin
      chain_reg <= chain_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (item_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= result;
    end
  end

  assign item_out.valid    = out_valid;
  assign item_out.data_out = out_data;

  // An accepted item always occupies the input stage in the next cycle.
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    item_in.valid && item_in.ready |=> stage_valid)
    else $error("accepted item did not reach the input stage");

  // An item leaving the stage always shows up as a result.
  a_adv_gives_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> item_out.valid)
    else $error("advanced item did not reach the result register");

  // After an encryption the chain holds the ciphertext just produced.
  a_enc_chain: assert property (@(posedge clk) disable iff (rst)
    adv && !is_dec |=> chain_reg == item_out.data_out)
    else $error("chain does not match the last ciphertext");

  // After a decryption the chain holds the ciphertext that came in.
  a_dec_chain: assert property (@(posedge clk) disable iff (rst)
    adv && is_dec |=> chain_reg == $past(stage_data))
    else $error("chain does not match the last input ciphertext");

endmodule

FILE: sim/fcbc_cipher_checker.sv
// Checker for the Feistel CBC block cipher: watches all channels, predicts each block and compares.
`timescale 1ns / 1ps

module fcbc_cipher_checker #(
  parameter int ROUNDS = fcbc_pkg::ROUNDS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  fcbc_in_if          item_in,
  fcbc_out_if         item_out,
  fcbc_cfg_if         cfg,
  output int unsigned outstanding,
  output int unsigned mismatches
);
  import fcbc_pkg::*;

  // Shadow copies of the key, the initial chain value and the chain register.
  half_t  key_word;
  block_t iv_block;
  block_t chain_block;

  // Inverse substitution table, derived from the forward table at start.
  byte_t  inv_lut [256];

  // Predicted output blocks, oldest first.
  block_t expected_blocks [$];

  initial begin
    for (int k = 0; k < 256; k++) begin
      inv_lut[FWD_SBOX[k]] = byte_t'(k);
    end
  end

  // Forward substitution on each byte of the key word.
  function automatic half_t sbox_word(input half_t w);
    half_t r;
    for (int b = 0; b < 4; b++) begin
      r[8*b +: 8] = FWD_SBOX[w[8*b +: 8]];
    end
    return r;
  endfunction

  // Round key: the substituted key rotated left by the round number.
  function automatic half_t round_subkey(input half_t base, input int i);
    if (i == 0) begin
      return base;
    end
    return (base << i) | (base >> (32 - i));
  endfunction

  // Round function: key mixing followed by inverse substitution of each byte.
  function automatic half_t feistel_f(input half_t half, input half_t k);
    half_t x;
    half_t r;
    x = half ^ k;
    for (int b = 0; b < 4; b++) begin
      r[8*b +: 8] = inv_lut[x[8*b +: 8]];
    end
    return r;
  endfunction

  function automatic block_t encipher(input block_t blk, input half_t base);
    half_t l;
    half_t r;
    half_t t;
    l = blk[63:32];
    r = blk[31:0];
    for (int i = 0; i < ROUNDS; i++) begin
      t = l ^ feistel_f(r, round_subkey(base, i));
      l = r;
      r = t;
    end
    return {l, r};
  endfunction

  function automatic block_t decipher(input block_t blk, input half_t base);
    half_t l;
    half_t r;
    half_t t;
    l = blk[63:32];
    r = blk[31:0];
    for (int i = ROUNDS - 1; i >= 0; i--) begin
      t = r ^ feistel_f(l, round_subkey(base, i));
      r = l;
      l = t;
    end
    return {l, r};
  endfunction

  // Works out the output block for one accepted item and advances the chain.
  function automatic block_t cbc_predict(input logic op, input logic st, input block_t din);
    block_t res;
    half_t  base;
    base = sbox_word(key_word);
    if (st) begin
      chain_block = iv_block;
    end
    if (op == OP_ENCRYPT) begin
      res = encipher(din ^ chain_block, base);
      chain_block = res;
    end else begin
      res = decipher(din, base) ^ chain_block;
      chain_block = din;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches = mismatches + 1;
  endtask

  // Sample every handshake at the clock edge and keep the expectations in order.
  always @(posedge clk) begin
    if (rst) begin
      key_word    = '0;
      iv_block    = '0;
      chain_block = '0;
      expected_blocks.delete();
      mismatches  = 0;
      outstanding <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_CIPHER_KEY: key_word = cfg.data[31:0];
          CFG_CHAIN_INIT: iv_block = cfg.data;
          default: ;
        endcase
      end
      if (item_in.valid && item_in.ready) begin
        expected_blocks.push_back(cbc_predict(item_in.op, item_in.chain_start,
                                              item_in.data_in));
      end
      if (item_out.valid && item_out.ready) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch($sformatf("unexpected output block %h", item_out.data_out));
        end else begin
          block_t want;
          want = expected_blocks.pop_front();
          if (item_out.data_out !== want) begin
            report_mismatch($sformatf("data_out %h, expected %h", item_out.data_out, want));
          end
        end
      end
      outstanding <= expected_blocks.size();
    end
  end

endmodule

FILE: sim/tb_feistel_cbc_block_cipher_top.sv
// Testbench top for the Feistel CBC block cipher: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_feistel_cbc_block_cipher_top;
  import fcbc_pkg::*;

  localparam int          STALL_LIMIT = 4000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          PHASE_ITEMS = 100;
  localparam int          NUM_PHASES  = 6;
  localparam cfg_index_t  CFG_SPARE_A = 2'd2;
  localparam cfg_index_t  CFG_SPARE_B = 2'd3;
  localparam block_t      ALL_ONES    = '1;

  logic clk;
  logic rst;

  fcbc_in_if  item_in ();
  fcbc_out_if item_out ();
  fcbc_cfg_if cfg ();

  int unsigned outstanding;
  int unsigned mismatches;

  // Sender burst state and the long receiver hold-off handshake.
  bit gaps_on;
  int burst_left;
  bit hold_req;
  bit hold_done;
  int idle_cycles;

  feistel_cbc_block_cipher_top dut (
    .clk      (clk),
    .rst      (rst),
    .item_in  (item_in),
    .item_out (item_out),
    .cfg      (cfg)
  );

  fcbc_cipher_checker cbc_check (
    .clk         (clk),
    .rst         (rst),
    .item_in     (item_in),
    .item_out    (item_out),
    .cfg         (cfg),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Random block, with the all-zero and all-one extremes now and then.
  function automatic block_t rand_block();
    case ($urandom_range(0, 19))
      0: return '0;
      1: return ALL_ONES;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Offers one item, waits for it to be taken, then maybe opens a gap.
  task automatic push_block(input logic op, input logic st, input block_t d);
    item_in.valid       <= 1'b1;
    item_in.op          <= op;
    item_in.chain_start <= st;
    item_in.data_in     <= d;
    @(posedge clk);
    while (!item_in.ready) @(posedge clk);
    if (gaps_on) begin
      if (burst_left == 0) begin
        item_in.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic write_reg(input cfg_index_t idx, input block_t d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= d;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering items and waits until every predicted block has come out.
  task automatic drain_results();
    item_in.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // One chain of random blocks; most start from the initial value and keep one op.
  task automatic send_chain(output int count);
    int   len;
    bit   mixed;
    bit   first_start;
    logic op0;
    logic op;
    logic st;
    len         = $urandom_range(1, 12);
    mixed       = ($urandom_range(0, 99) < 15);
    first_start = ($urandom_range(0, 9) != 0);
    op0         = logic'($urandom_range(0, 1));
    for (int j = 0; j < len; j++) begin
      op = mixed ? logic'($urandom_range(0, 1)) : op0;
      st = (j == 0) ? first_start : ($urandom_range(0, 49) == 0);
      push_block(op, st, rand_block());
    end
    count = len;
  endtask

  // Receiver: changes stall pattern every so often and honors one long hold-off.
  initial begin
    int mode;
    int span;
    int tick;
    item_out.ready = 1'b0;
    hold_done      = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(40, 200);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (hold_req && !hold_done) begin
          item_out.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0: item_out.ready <= 1'b1;
          1: item_out.ready <= logic'($urandom_range(0, 1));
          2: item_out.ready <= ($urandom_range(0, 3) == 0);
          default: item_out.ready <= ((tick % 5) != 0);
        endcase
      end
    end
  end

  // Watchdog: ends the run when nothing has been accepted for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_in.valid && item_in.ready) || (item_out.valid && item_out.ready) ||
          (cfg.valid && cfg.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus: directed corner cases, then random phases under several settings.
  initial begin
    int   sent;
    int   n;
    block_t key_val;
    block_t iv_val;
    rst                 = 1'b1;
    item_in.valid       = 1'b0;
    item_in.op          = OP_ENCRYPT;
    item_in.chain_start = 1'b0;
    item_in.data_in     = '0;
    cfg.valid           = 1'b0;
    cfg.index           = CFG_CIPHER_KEY;
    cfg.data            = '0;
    gaps_on             = 1'b1;
    burst_left          = 0;
    hold_req            = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Chain never started: reset value, then the last ciphertext.
    push_block(OP_ENCRYPT, 1'b0, '0);
    push_block(OP_ENCRYPT, 1'b0, ALL_ONES);
    push_block(OP_DECRYPT, 1'b0, ALL_ONES);
    drain_results();

    // Largest key and initial value; writes past the register list are ignored.
    write_reg(CFG_CIPHER_KEY, ALL_ONES);
    write_reg(CFG_CHAIN_INIT, ALL_ONES);
    write_reg(CFG_SPARE_A, {$urandom(), $urandom()});
    write_reg(CFG_SPARE_B, {$urandom(), $urandom()});
    push_block(OP_ENCRYPT, 1'b1, '0);
    push_block(OP_ENCRYPT, 1'b0, ALL_ONES);
    push_block(OP_DECRYPT, 1'b0, 64'h0123_4567_89ab_cdef);
    push_block(OP_ENCRYPT, 1'b0, rand_block());
    push_block(OP_DECRYPT, 1'b1, ALL_ONES);
    push_block(OP_DECRYPT, 1'b0, '0);
    push_block(OP_ENCRYPT, 1'b1, ALL_ONES);
    drain_results();

    // Zero key and zero initial value.
    write_reg(CFG_CIPHER_KEY, '0);
    write_reg(CFG_CHAIN_INIT, '0);
    push_block(OP_ENCRYPT, 1'b1, '0);
    push_block(OP_DECRYPT, 1'b1, '0);
    push_block(OP_ENCRYPT, 1'b1, ALL_ONES);
    push_block(OP_DECRYPT, 1'b0, ALL_ONES);
    drain_results();

    // A typical key with a single set bit at each end.
    write_reg(CFG_CIPHER_KEY, 64'h0000_0000_8000_0001);
    write_reg(CFG_CHAIN_INIT, {$urandom(), $urandom()});
    push_block(OP_DECRYPT, 1'b1, rand_block());
    push_block(OP_DECRYPT, 1'b0, rand_block());
    push_block(OP_ENCRYPT, 1'b1, rand_block());
    push_block(OP_ENCRYPT, 1'b0, rand_block());
    drain_results();

    // Random phases, each under its own key and initial value.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          key_val = '0;
          iv_val  = ALL_ONES;
        end
        1: begin
          key_val = ALL_ONES;
          iv_val  = '0;
        end
        default: begin
          key_val = {$urandom(), $urandom()};
          iv_val  = {$urandom(), $urandom()};
        end
      endcase
      write_reg(CFG_CIPHER_KEY, key_val);
      write_reg(CFG_CHAIN_INIT, iv_val);
      if (p == 3) begin
        write_reg(CFG_SPARE_B, {$urandom(), $urandom()});
        write_reg(CFG_SPARE_A, {$urandom(), $urandom()});
      end
      gaps_on = (p != 2) && (p != 4);
      // Back-to-back items against a long output stall fill the block.
      if (p == 2) begin
        hold_req = 1'b1;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_chain(n);
        sent += n;
        if ($urandom_range(0, 19) == 0) begin
          drain_results();
        end
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/fcbc_pkg.sv
hw/rtl/fcbc_in_if.sv
hw/rtl/fcbc_out_if.sv
hw/rtl/fcbc_cfg_if.sv
hw/rtl/fcbc_round.sv
hw/rtl/fcbc_cipher.sv
hw/rtl/feistel_cbc_block_cipher_top.sv
sim/fcbc_cipher_checker.sv
sim/tb_feistel_cbc_block_cipher_top.sv
